### src/dfm_pkg.sv
// ----------------------------------------------------------------------------
// dfm_pkg: shared definitions for the dual frequency monitor
// Widths, item function codes, register indexes and the control and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dfm_pkg;

	localparam int PERIOD_BITS = 20;
	localparam int COUNT_BITS  = 8;
	localparam int FREQ_W      = 20;
	localparam int VAL_W       = 21;
	localparam int RANGE_W     = VAL_W + 1;
	localparam int CNT_OUT_W   = 8;
	localparam int OFFSET_W    = 11;
	localparam int DRIFT_W     = 10;
	localparam int HIGH_W      = 14;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 14;
	localparam int DIV_STEPS   = FREQ_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [FREQ_W-1:0]     FREQ_NUM        = FREQ_W'(1000000);
	localparam logic [OFFSET_W-1:0]   OFFSET_RESET    = '0;
	localparam logic [DRIFT_W-1:0]    DRIFT_RESET     = DRIFT_W'(1000);
	localparam logic [HIGH_W-1:0]     HIGH_RESET      = HIGH_W'(5000);
	localparam logic [DIV_CNT_W-1:0]  DIV_LAST_STEP   = DIV_CNT_W'(DIV_STEPS - 1);

	typedef enum logic [1:0] {
		FUNC_CAPTURE    = 2'd0,
		FUNC_SAMPLE     = 2'd1,
		FUNC_WINDOW_END = 2'd2,
		FUNC_CLEAR      = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET = 2'd0,
		CFG_DRIFT  = 2'd1,
		CFG_HIGH   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic apply;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
	} sts_t;

endpackage

### src/dfm_if.sv
// ----------------------------------------------------------------------------
// dfm_in_if / dfm_out_if: item channels of the dual frequency monitor
// Valid and ready handshake with the item fields as payload.
// ----------------------------------------------------------------------------
interface dfm_in_if import dfm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             func;
	logic                   channel;
	logic [PERIOD_BITS-1:0] period_us;

	modport source (output valid, output func, output channel, output period_us,
		input ready);
	modport sink (input valid, input func, input channel, input period_us,
		output ready);
endinterface

interface dfm_out_if import dfm_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [VAL_W-1:0]     adjusted_a;
	logic signed [VAL_W-1:0]     adjusted_b;
	logic [CNT_OUT_W-1:0]        high_count_a;
	logic [CNT_OUT_W-1:0]        high_count_b;
	logic [CNT_OUT_W-1:0]        drift_count_a;
	logic [CNT_OUT_W-1:0]        drift_count_b;

	modport source (output valid, output adjusted_a, output adjusted_b,
		output high_count_a, output high_count_b, output drift_count_a,
		output drift_count_b, input ready);
	modport sink (input valid, input adjusted_a, input adjusted_b,
		input high_count_a, input high_count_b, input drift_count_a,
		input drift_count_b, output ready);
endinterface

### src/dfm_ctrl.sv
// ----------------------------------------------------------------------------
// dfm_ctrl: sequencing controller
// Takes one item at a time, runs the divider for captures with a nonzero period,
// applies the update and hands the result to the output register.
// ----------------------------------------------------------------------------
module dfm_ctrl import dfm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_DISPATCH = 5'b00010,
		ST_DIV      = 5'b00100,
		ST_APPLY    = 5'b01000,
		ST_EMIT     = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_d = sts.need_div ? ST_DIV : ST_APPLY;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/dfm_dp.sv
// ----------------------------------------------------------------------------
// dfm_dp: monitor datapath
// Item and configuration registers, a restoring divider one quotient bit per
// cycle, the window and threshold tracking, event counters and result register.
// ----------------------------------------------------------------------------
module dfm_dp import dfm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_idx,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic [1:0]               in_func,
	input  logic                     in_channel,
	input  logic [PERIOD_BITS-1:0]   in_period_us,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	output logic signed [VAL_W-1:0]  adjusted_a,
	output logic signed [VAL_W-1:0]  adjusted_b,
	output logic [CNT_OUT_W-1:0]     high_count_a,
	output logic [CNT_OUT_W-1:0]     high_count_b,
	output logic [CNT_OUT_W-1:0]     drift_count_a,
	output logic [CNT_OUT_W-1:0]     drift_count_b
);

	// Item and divider registers
	func_t                   func_q;
	logic                    channel_q;
	logic [PERIOD_BITS-1:0]  period_q;
	logic [FREQ_W-1:0]       rem_q;
	logic [FREQ_W-1:0]       quo_q;
	logic [DIV_CNT_W-1:0]    div_cnt_q;

	// Configuration
	logic signed [OFFSET_W-1:0] offset_q;
	logic [DRIFT_W-1:0]         drift_q;
	logic [HIGH_W-1:0]          high_q;

	// Monitor state
	logic [FREQ_W-1:0]        freq_q [2];
	logic signed [VAL_W-1:0]  sampled_q [2];
	logic signed [VAL_W-1:0]  wmax_q [2];
	logic signed [VAL_W-1:0]  wmin_q [2];
	logic                     started_q;
	logic                     above_q [2];
	logic [COUNT_BITS-1:0]    high_cnt_q [2];
	logic [COUNT_BITS-1:0]    drift_cnt_q [2];

	// Result register
	logic signed [VAL_W-1:0]  res_adj_q [2];
	logic [CNT_OUT_W-1:0]     res_high_q [2];
	logic [CNT_OUT_W-1:0]     res_drift_q [2];

	logic [FREQ_W:0]           rem_shift;
	logic                      rem_ge;
	logic [FREQ_W-1:0]         rem_sub;
	logic signed [VAL_W-1:0]   offset_ext;
	logic signed [VAL_W-1:0]   high_ext;
	logic signed [RANGE_W-1:0] drift_ext;
	logic signed [VAL_W-1:0]   samp [2];
	logic signed [VAL_W-1:0]   base_max [2];
	logic signed [VAL_W-1:0]   base_min [2];
	logic signed [RANGE_W-1:0] range_v [2];
	logic                      samp_high [2];
	logic                      drift_hit [2];

	assign sts.need_div = (func_q == FUNC_CAPTURE) && (period_q != '0);
	assign sts.div_last = (div_cnt_q == DIV_LAST_STEP);

	// The remainder stays below the period, so it always fits in FREQ_W bits.
	assign rem_shift = {rem_q, quo_q[FREQ_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, period_q});
	assign rem_sub   = rem_shift[FREQ_W-1:0] - period_q;

	assign offset_ext = {{(VAL_W - OFFSET_W){offset_q[OFFSET_W-1]}}, offset_q};
	assign high_ext   = {{(VAL_W - HIGH_W){1'b0}}, high_q};
	assign drift_ext  = {{(RANGE_W - DRIFT_W){1'b0}}, drift_q};

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			samp[i]      = $signed({1'b0, freq_q[i]}) + offset_ext;
			base_max[i]  = started_q ? wmax_q[i] : samp[i];
			base_min[i]  = started_q ? wmin_q[i] : samp[i];
			samp_high[i] = (samp[i] > high_ext);
			range_v[i]   = {wmax_q[i][VAL_W-1], wmax_q[i]} - {wmin_q[i][VAL_W-1], wmin_q[i]};
			drift_hit[i] = (range_v[i] > drift_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= func_t'(in_func);
			channel_q <= in_channel;
			period_q  <= in_period_us;
			rem_q     <= '0;
			quo_q     <= FREQ_NUM;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= rem_ge ? rem_sub : rem_shift[FREQ_W-1:0];
			quo_q     <= {quo_q[FREQ_W-2:0], rem_ge};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (cmd.emit) begin
			for (int i = 0; i < 2; i++) begin
				res_adj_q[i]   <= sampled_q[i];
				res_high_q[i]  <= CNT_OUT_W'(high_cnt_q[i]);
				res_drift_q[i] <= CNT_OUT_W'(drift_cnt_q[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q  <= OFFSET_RESET;
			drift_q   <= DRIFT_RESET;
			high_q    <= HIGH_RESET;
			started_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				freq_q[i]      <= '0;
				sampled_q[i]   <= '0;
				wmax_q[i]      <= '0;
				wmin_q[i]      <= '0;
				above_q[i]     <= 1'b0;
				high_cnt_q[i]  <= '0;
				drift_cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_OFFSET: offset_q <= cfg_data[OFFSET_W-1:0];
					CFG_DRIFT:  drift_q  <= cfg_data[DRIFT_W-1:0];
					CFG_HIGH:   high_q   <= cfg_data[HIGH_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.apply) begin
				case (func_q)
					FUNC_CAPTURE: begin
						freq_q[channel_q] <= (period_q == '0) ? '0 : quo_q;
					end
					FUNC_SAMPLE: begin
						started_q <= 1'b1;
						for (int i = 0; i < 2; i++) begin
							sampled_q[i] <= samp[i];
							wmax_q[i]    <= base_max[i];
							wmin_q[i]    <= base_min[i];
							if (samp[i] > base_max[i]) begin
								wmax_q[i] <= samp[i];
							end else if (samp[i] < base_min[i]) begin
								wmin_q[i] <= samp[i];
							end
							if (samp_high[i]) begin
								if (!above_q[i]) begin
									high_cnt_q[i] <= high_cnt_q[i] + 1'b1;
								end
								above_q[i] <= 1'b1;
							end else begin
								above_q[i] <= 1'b0;
							end
						end
					end
					FUNC_WINDOW_END: begin
						started_q <= 1'b0;
						for (int i = 0; i < 2; i++) begin
							if (drift_hit[i]) begin
								drift_cnt_q[i] <= drift_cnt_q[i] + 1'b1;
							end
						end
					end
					FUNC_CLEAR: begin
						for (int i = 0; i < 2; i++) begin
							high_cnt_q[i]  <= '0;
							drift_cnt_q[i] <= '0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign adjusted_a    = res_adj_q[0];
	assign adjusted_b    = res_adj_q[1];
	assign high_count_a  = res_high_q[0];
	assign high_count_b  = res_high_q[1];
	assign drift_count_a = res_drift_q[0];
	assign drift_count_b = res_drift_q[1];

endmodule

### src/dual_frequency_monitor_top.sv
// Sequence: an accepted item passes dispatch, then for a capture with a nonzero
// period the one-bit-per-cycle divider, then apply and emit into the result register.
// Flow: one item at a time; the input is ready again as soon as the result
// enters the output register.
// Reset: arst_n asynchronously resets control, monitor state and config defaults.
// ----------------------------------------------------------------------------
// dual_frequency_monitor_top: two-channel frequency monitor
// Converts captured periods to frequencies, tracks window range and threshold
// crossings per channel, and reports the adjusted values and event counts.
// ----------------------------------------------------------------------------
module dual_frequency_monitor_top import dfm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	dfm_in_if.sink                in_ch,
	dfm_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	dfm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dfm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.in_func       (in_ch.func),
		.in_channel    (in_ch.channel),
		.in_period_us  (in_ch.period_us),
		.cmd           (cmd),
		.sts           (sts),
		.adjusted_a    (out_ch.adjusted_a),
		.adjusted_b    (out_ch.adjusted_b),
		.high_count_a  (out_ch.high_count_a),
		.high_count_b  (out_ch.high_count_b),
		.drift_count_a (out_ch.drift_count_a),
		.drift_count_b (out_ch.drift_count_b)
	);

endmodule

### src/dfm_checker.sv
// ----------------------------------------------------------------------------
// dfm_checker: port-level checks for the dual frequency monitor
// Watches the item handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module dfm_checker import dfm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic signed [VAL_W-1:0] adjusted_a,
	input logic [CNT_OUT_W-1:0] high_count_a
);

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// A waiting result stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(adjusted_a) && $stable(high_count_a))
		else $error("result payload changed while stalled");

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("second item accepted while one is in work");

	// No result can appear while the accepted item is still in dispatch or apply.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result appeared too early after an accepted item");

endmodule

bind dual_frequency_monitor_top dfm_checker u_dfm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.adjusted_a   (out_ch.adjusted_a),
	.high_count_a (out_ch.high_count_a)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for dual_frequency_monitor_top
// Drives capture, sample, window-end and clear items through the item channel
// and checks every result against a cycle-free prediction of the monitor.
// ----------------------------------------------------------------------------
module tb;
	import dfm_pkg::*;

	typedef struct {
		logic signed [VAL_W-1:0] adj_a;
		logic signed [VAL_W-1:0] adj_b;
		logic [CNT_OUT_W-1:0]    high_a;
		logic [CNT_OUT_W-1:0]    high_b;
		logic [CNT_OUT_W-1:0]    drift_a;
		logic [CNT_OUT_W-1:0]    drift_b;
	} monitor_report_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	dfm_in_if  in_ch ();
	dfm_out_if out_ch ();

	dual_frequency_monitor_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	logic signed [OFFSET_W-1:0] offset_reg = OFFSET_RESET;
	logic [DRIFT_W-1:0]         drift_reg  = DRIFT_RESET;
	logic [HIGH_W-1:0]          high_reg   = HIGH_RESET;

	logic [FREQ_W-1:0]     freq_a = '0;
	logic [FREQ_W-1:0]     freq_b = '0;
	int                    adjusted[2] = '{0, 0};
	int                    win_hi[2] = '{0, 0};
	int                    win_lo[2] = '{0, 0};
	bit                    window_open = 1'b0;
	bit                    above[2] = '{1'b0, 1'b0};
	logic [COUNT_BITS-1:0] event_count[4] = '{default: '0};

	monitor_report_t reports_due[$];
	monitor_report_t report_want;

	int mismatch_count = 0;
	int items_sent     = 0;
	int send_idle_pct  = 24;
	int recv_idle_pct  = 59;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("** dual_frequency_monitor_top: FAILED **");
		$finish;
	end

	function automatic void follow_channel(int c, int v);
		if (v > win_hi[c])
			win_hi[c] = v;
		else if (v < win_lo[c])
			win_lo[c] = v;
		if (v > int'(high_reg)) begin
			if (!above[c]) begin
				event_count[c] = event_count[c] + 1'b1;
				above[c] = 1'b1;
			end
		end else begin
			above[c] = 1'b0;
		end
	endfunction

	function automatic void apply_monitor_item(func_t f, logic ch, logic [PERIOD_BITS-1:0] p);
		monitor_report_t rep;
		logic [FREQ_W-1:0] q;
		case (f)
			FUNC_CAPTURE: begin
				q = (p == '0) ? '0 : FREQ_W'(1000000 / p);
				if (ch)
					freq_b = q;
				else
					freq_a = q;
			end
			FUNC_SAMPLE: begin
				adjusted[0] = int'(freq_a) + int'(offset_reg);
				adjusted[1] = int'(freq_b) + int'(offset_reg);
				if (!window_open) begin
					for (int i = 0; i < 2; i++) begin
						win_hi[i] = adjusted[i];
						win_lo[i] = adjusted[i];
					end
					window_open = 1'b1;
				end
				follow_channel(0, adjusted[0]);
				follow_channel(1, adjusted[1]);
			end
			FUNC_WINDOW_END: begin
				for (int i = 0; i < 2; i++)
					if (win_hi[i] - win_lo[i] > int'(drift_reg))
						event_count[2 + i] = event_count[2 + i] + 1'b1;
				window_open = 1'b0;
			end
			default: begin
				for (int i = 0; i < 4; i++)
					event_count[i] = '0;
			end
		endcase
		rep.adj_a   = VAL_W'(adjusted[0]);
		rep.adj_b   = VAL_W'(adjusted[1]);
		rep.high_a  = CNT_OUT_W'(event_count[0]);
		rep.high_b  = CNT_OUT_W'(event_count[1]);
		rep.drift_a = CNT_OUT_W'(event_count[2]);
		rep.drift_b = CNT_OUT_W'(event_count[3]);
		reports_due.push_back(rep);
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
		logic signed [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(negedge clk)
		out_ch.ready = (arst_n === 1'b1) && ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (reports_due.size() == 0) begin
				mismatch_count++;
				$display("%0t: result arrived with no item outstanding", $time);
			end else begin
				report_want = reports_due.pop_front();
				check_field("adjusted_a", report_want.adj_a, out_ch.adjusted_a);
				check_field("adjusted_b", report_want.adj_b, out_ch.adjusted_b);
				check_field("high_count_a", report_want.high_a, out_ch.high_count_a);
				check_field("high_count_b", report_want.high_b, out_ch.high_count_b);
				check_field("drift_count_a", report_want.drift_a, out_ch.drift_count_a);
				check_field("drift_count_b", report_want.drift_b, out_ch.drift_count_b);
			end
		end
	end

	task automatic send_item(func_t f, logic ch, logic [PERIOD_BITS-1:0] p);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid     = 1'b1;
		in_ch.func      = f;
		in_ch.channel   = ch;
		in_ch.period_us = p;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		apply_monitor_item(f, ch, p);
		items_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		drain_results();
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = data;
		@(posedge clk);
		case (idx)
			CFG_OFFSET: offset_reg = data[OFFSET_W-1:0];
			CFG_DRIFT:  drift_reg  = data[DRIFT_W-1:0];
			default:    high_reg   = data[HIGH_W-1:0];
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [PERIOD_BITS-1:0] pick_period();
		int target;
		case ($urandom_range(9))
			0: return '0;
			1: return PERIOD_BITS'($urandom());
			2: return PERIOD_BITS'($urandom_range(1, 99));
			default: begin
				target = int'(high_reg) - int'(offset_reg) + int'($urandom_range(0, 400)) - 200;
				if (target < 1)
					target = 1;
				return PERIOD_BITS'(1000000 / target);
			end
		endcase
	endfunction

	task automatic send_noise_item(func_t f);
		send_item(f, 1'($urandom()), PERIOD_BITS'($urandom()));
	endtask

	// The first sample after reset opens the window on zero frequencies.
	task automatic test_window_start_and_zero_period();
		send_item(FUNC_SAMPLE, 1'b0, '0);
		send_item(FUNC_CAPTURE, 1'b0, '0);
		send_item(FUNC_CAPTURE, 1'b1, '0);
		send_item(FUNC_SAMPLE, 1'b1, '1);
	endtask

	task automatic test_capture_and_threshold();
		send_item(FUNC_CAPTURE, 1'b1, PERIOD_BITS'(1));
		send_item(FUNC_CAPTURE, 1'b0, '1);
		send_item(FUNC_SAMPLE, 1'b0, '0);
		send_item(FUNC_CAPTURE, 1'b0, PERIOD_BITS'(200));
		send_item(FUNC_SAMPLE, 1'b0, '0);
		send_item(FUNC_CAPTURE, 1'b0, PERIOD_BITS'(199));
		send_item(FUNC_SAMPLE, 1'b0, '0);
		send_item(FUNC_SAMPLE, 1'b1, '1);
		send_item(FUNC_CAPTURE, 1'b0, PERIOD_BITS'(200));
		send_item(FUNC_SAMPLE, 1'b0, '0);
		send_item(FUNC_CAPTURE, 1'b0, PERIOD_BITS'(199));
		send_item(FUNC_SAMPLE, 1'b0, '0);
		send_item(FUNC_WINDOW_END, 1'b1, '1);
		send_item(FUNC_CLEAR, 1'b1, '1);
		send_item(FUNC_WINDOW_END, 1'b0, '0);
	endtask

	// Negative adjusted values must stay below a small unsigned threshold.
	task automatic test_signed_compare();
		write_reg(CFG_OFFSET, CFG_DATA_W'(-1000));
		write_reg(CFG_HIGH, CFG_DATA_W'(100));
		write_reg(CFG_DRIFT, CFG_DATA_W'(100));
		send_item(FUNC_CAPTURE, 1'b0, '0);
		send_item(FUNC_CAPTURE, 1'b1, PERIOD_BITS'(1100));
		send_item(FUNC_SAMPLE, 1'b0, '0);
		send_item(FUNC_CAPTURE, 1'b1, PERIOD_BITS'(1));
		send_item(FUNC_SAMPLE, 1'b0, '0);
		send_item(FUNC_WINDOW_END, 1'b0, '0);
	endtask

	// Alternating the offset around the threshold drives the channel A crossing
	// counter past its wrap point and steps the other counters at random.
	task automatic test_counter_wrap();
		int up;
		int down;
		write_reg(CFG_HIGH, CFG_DATA_W'(5000));
		write_reg(CFG_DRIFT, CFG_DATA_W'(100));
		write_reg(CFG_OFFSET, '0);
		send_item(FUNC_CAPTURE, 1'b0, PERIOD_BITS'(200));
		send_item(FUNC_CAPTURE, 1'b1, PERIOD_BITS'(199));
		for (int i = 0; i < 260; i++) begin
			up   = (i == 0) ? 1000 : int'($urandom_range(1, 1000));
			down = (i == 0) ? 1000 : int'($urandom_range(0, 1000));
			write_reg(CFG_OFFSET, CFG_DATA_W'(up));
			send_noise_item(FUNC_SAMPLE);
			write_reg(CFG_OFFSET, CFG_DATA_W'(-down));
			send_noise_item(FUNC_SAMPLE);
			send_noise_item(FUNC_WINDOW_END);
		end
	endtask

	task automatic run_random_items(int n);
		int stop;
		int pick;
		stop = items_sent + n;
		while (items_sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				repeat ($urandom_range(1, 5)) begin
					repeat ($urandom_range(0, 2))
						send_item(FUNC_CAPTURE, 1'($urandom()), pick_period());
					send_noise_item(FUNC_SAMPLE);
				end
				send_noise_item(FUNC_WINDOW_END);
			end else if (pick < 75) begin
				send_noise_item(FUNC_CLEAR);
			end else if (pick < 77) begin
				drain_results();
			end else begin
				send_noise_item(func_t'($urandom_range(3)));
			end
		end
	endtask

	task automatic test_random_traffic();
		write_reg(CFG_OFFSET, CFG_DATA_W'(1000));
		write_reg(CFG_DRIFT, CFG_DATA_W'(1000));
		write_reg(CFG_HIGH, CFG_DATA_W'(10000));
		run_random_items(140);
		send_idle_pct = 59;
		recv_idle_pct = 24;
		write_reg(CFG_OFFSET, CFG_DATA_W'(-1000));
		write_reg(CFG_DRIFT, CFG_DATA_W'(100));
		write_reg(CFG_HIGH, CFG_DATA_W'(100));
		run_random_items(140);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_OFFSET, CFG_DATA_W'(int'($urandom_range(0, 2000)) - 1000));
		write_reg(CFG_DRIFT, CFG_DATA_W'($urandom_range(100, 1000)));
		write_reg(CFG_HIGH, CFG_DATA_W'($urandom_range(100, 10000)));
		run_random_items(140);
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_idx         = CFG_OFFSET;
		cfg_data        = '0;
		in_ch.valid     = 1'b0;
		in_ch.func      = FUNC_CAPTURE;
		in_ch.channel   = 1'b0;
		in_ch.period_us = '0;
		out_ch.ready    = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_window_start_and_zero_period();
		test_capture_and_threshold();
		test_signed_compare();
		test_counter_wrap();
		test_random_traffic();

		drain_results();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0 && reports_due.size() == 0)
			$display("** dual_frequency_monitor_top: PASSED **");
		else
			$display("** dual_frequency_monitor_top: FAILED **");
		$finish;
	end

endmodule
